### sv/cbm_pkg.sv
package cbm_pkg;

   // Field and register widths
   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int MAP_W       = 21;
   localparam int REGION_W    = 2;
   localparam int ROM_CNT_W   = 10;
   localparam int RAM_CNT_W   = 5;
   localparam int ROM_SEL_W   = 7;
   localparam int RAM_SEL_W   = 4;
   localparam int CSR_DATA_W  = ROM_CNT_W;
   localparam int DIV_BITS    = ROM_SEL_W;
   localparam int DIV_IDX_W   = $clog2(DIV_BITS);

   // Item command codes
   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   // Configuration register indexes
   localparam logic CSR_ROM_BANK_COUNT = 1'b0;
   localparam logic CSR_RAM_BANK_COUNT = 1'b1;

   // Result region codes
   localparam logic [REGION_W-1:0] REGION_ROM  = 2'd0;
   localparam logic [REGION_W-1:0] REGION_RAM  = 2'd1;
   localparam logic [REGION_W-1:0] REGION_RTC  = 2'd2;
   localparam logic [REGION_W-1:0] REGION_NONE = 2'd3;

   // Bus address map
   localparam logic [ADDR_W-1:0] RAM_EN_LAST   = 16'h1FFF;
   localparam logic [ADDR_W-1:0] ROM_SEL_FIRST = 16'h2000;
   localparam logic [ADDR_W-1:0] ROM_SEL_LAST  = 16'h3FFF;
   localparam logic [ADDR_W-1:0] RAM_SEL_FIRST = 16'h4000;
   localparam logic [ADDR_W-1:0] RAM_SEL_LAST  = 16'h5FFF;
   localparam logic [ADDR_W-1:0] LATCH_FIRST   = 16'h6000;
   localparam logic [ADDR_W-1:0] LATCH_LAST    = 16'h7FFF;
   localparam logic [ADDR_W-1:0] BANK0_LAST    = 16'h3FFF;
   localparam logic [ADDR_W-1:0] ROMX_LAST     = 16'h7FFF;
   localparam logic [ADDR_W-1:0] XRAM_FIRST    = 16'hA000;
   localparam logic [ADDR_W-1:0] XRAM_LAST     = 16'hBFFF;

   // Data codes
   localparam logic [3:0]          RAM_EN_KEY    = 4'hA;
   localparam logic [DATA_W-1:0]   RAM_BANK_MAX  = 8'd7;
   localparam logic [DATA_W-1:0]   RTC_SEL_FIRST = 8'd8;
   localparam logic [DATA_W-1:0]   RTC_SEL_LAST  = 8'h0C;
   localparam logic [DATA_W-1:0]   LATCH_ARM     = 8'd1;
   localparam logic [RAM_SEL_W-1:0] RAM_SEL_MAX  = 4'd12;
   localparam logic [RAM_SEL_W-1:0] RTC_BASE_SEL = 4'd8;

   // Reset values
   localparam logic [ROM_CNT_W-1:0] ROM_CNT_RESET = 10'd128;
   localparam logic [RAM_CNT_W-1:0] RAM_CNT_RESET = 5'd4;
   localparam logic [ROM_SEL_W-1:0] ROM_SEL_RESET = 7'd1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic div_start;
      logic div_step;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

### sv/cbm_ctrl.sv
module cbm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cbm_pkg::sts_type sts,
   output cbm_pkg::cmd_type cmd
);
   import cbm_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Sequence one item: take it, evaluate, divide if a bank write needs it, commit
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("commit while result register is held");

   a_div_only_when_needed: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> sts.need_div)
      else $error("division started for an item that needs none");

   a_div_ends_in_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && sts.div_last) |=> state_ff == ST_FIN)
      else $error("division did not hand over to finish");

endmodule

### sv/cbm_datapath.sv
module cbm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cbm_pkg::cmd_type                     cmd,
   output cbm_pkg::sts_type                     sts,
   input  logic                                 req_command,
   input  logic [cbm_pkg::ADDR_W-1:0]           req_bus_address,
   input  logic [cbm_pkg::DATA_W-1:0]           req_write_data,
   input  logic                                 csr_write_enable,
   input  logic                                 csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]       csr_write_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cbm_pkg::MAP_W-1:0]            rsp_mapped_address,
   output logic [cbm_pkg::REGION_W-1:0]         rsp_region,
   output logic                                 rsp_address_valid,
   output logic                                 rsp_ram_enabled,
   output logic                                 rsp_rtc_tick_pulse
);
   import cbm_pkg::*;

   // Captured item
   logic                 item_cmd_ff;
   logic [ADDR_W-1:0]    item_addr_ff;
   logic [DATA_W-1:0]    item_data_ff;

   // Configuration
   logic [ROM_CNT_W-1:0] rom_count_ff;
   logic [RAM_CNT_W-1:0] ram_count_ff;

   // Mapper state
   logic [ROM_SEL_W-1:0] rom_sel_ff, rom_sel_in;
   logic [RAM_SEL_W-1:0] ram_sel_ff, ram_sel_in;
   logic                 ram_en_ff, ram_en_in;
   logic [DATA_W-1:0]    latch_ff, latch_in;

   // Divider
   logic [ROM_SEL_W-1:0] rem_ff, rem_in;
   logic [DIV_IDX_W-1:0] bit_idx_ff;
   logic [ROM_SEL_W-1:0] dividend;
   logic [ROM_CNT_W-1:0] divisor;
   logic [ROM_SEL_W:0]   trial;
   logic [ROM_CNT_W-1:0] trial_ext;
   logic [ROM_CNT_W-1:0] trial_diff;

   // Result register
   logic                 rsp_valid_ff;
   logic [MAP_W-1:0]     map_ff, map_in;
   logic [REGION_W-1:0]  region_ff, region_in;
   logic                 addr_valid_ff, addr_valid_in;
   logic                 ram_enabled_ff;
   logic                 pulse_ff, pulse_in;

   // Decode
   logic                 is_write;
   logic                 in_en_rng, in_rom_rng, in_ram_rng, in_latch_rng;
   logic [ROM_SEL_W-1:0] rom_v;
   logic                 data_low_bank, data_rtc;
   logic                 need_div_rom, need_div_ram;
   logic [RAM_SEL_W-1:0] rtc_slot;

   assign is_write     = (item_cmd_ff == CMD_WRITE);
   assign in_en_rng    = (item_addr_ff <= RAM_EN_LAST);
   assign in_rom_rng   = (item_addr_ff >= ROM_SEL_FIRST) && (item_addr_ff <= ROM_SEL_LAST);
   assign in_ram_rng   = (item_addr_ff >= RAM_SEL_FIRST) && (item_addr_ff <= RAM_SEL_LAST);
   assign in_latch_rng = (item_addr_ff >= LATCH_FIRST) && (item_addr_ff <= LATCH_LAST);
   assign rom_v        = item_data_ff[ROM_SEL_W-1:0];
   assign data_low_bank = (item_data_ff != '0) && (item_data_ff <= RAM_BANK_MAX);
   assign data_rtc     = (item_data_ff >= RTC_SEL_FIRST) && (item_data_ff <= RTC_SEL_LAST);

   assign need_div_rom = is_write && in_rom_rng && (rom_v != '0) && (rom_count_ff != '0);
   assign need_div_ram = is_write && in_ram_rng && data_low_bank && (ram_count_ff != '0);

   assign sts.need_div = need_div_rom || need_div_ram;
   assign sts.div_last = (bit_idx_ff == '0);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // Restoring remainder, one dividend bit per cycle, MSB first
   assign dividend   = need_div_rom ? rom_v : item_data_ff[ROM_SEL_W-1:0];
   assign divisor    = need_div_rom ? rom_count_ff
                                    : {{(ROM_CNT_W-RAM_CNT_W){1'b0}}, ram_count_ff};
   assign trial      = {rem_ff, dividend[bit_idx_ff]};
   assign trial_ext  = {{(ROM_CNT_W-ROM_SEL_W-1){1'b0}}, trial};
   assign trial_diff = trial_ext - divisor;
   assign rem_in     = (trial_ext >= divisor) ? trial_diff[ROM_SEL_W-1:0]
                                              : trial[ROM_SEL_W-1:0];

   // Next mapper state for a register write
   always_comb begin
      rom_sel_in = rom_sel_ff;
      ram_sel_in = ram_sel_ff;
      ram_en_in  = ram_en_ff;
      latch_in   = latch_ff;
      pulse_in   = 1'b0;
      if (is_write) begin
         if (in_en_rng) begin
            ram_en_in = (item_data_ff[3:0] == RAM_EN_KEY);
         end else if (in_rom_rng) begin
            if (rom_v == '0) begin
               rom_sel_in = ROM_SEL_RESET;
            end else if (rom_count_ff == '0) begin
               rom_sel_in = rom_v;
            end else begin
               rom_sel_in = rem_ff;
            end
         end else if (in_ram_rng) begin
            if (item_data_ff == '0) begin
               ram_sel_in = '0;
            end else if (data_low_bank) begin
               if (ram_count_ff != '0) begin
                  ram_sel_in = rem_ff[RAM_SEL_W-1:0];
               end
            end else if (data_rtc) begin
               ram_sel_in = item_data_ff[RAM_SEL_W-1:0];
            end
         end else if (in_latch_rng) begin
            pulse_in = (item_data_ff == LATCH_ARM) && (latch_ff == '0);
            latch_in = item_data_ff;
         end
      end
   end

   // RTC slot index: selection 8..12 maps to 0..4
   assign rtc_slot = ram_sel_ff - RTC_BASE_SEL;

   // Translate the bus address against the current banks
   always_comb begin
      map_in        = '0;
      region_in     = REGION_NONE;
      addr_valid_in = 1'b0;
      if (!is_write) begin
         if (item_addr_ff <= BANK0_LAST) begin
            map_in        = {{(MAP_W-ADDR_W){1'b0}}, item_addr_ff};
            region_in     = REGION_ROM;
            addr_valid_in = 1'b1;
         end else if (item_addr_ff <= ROMX_LAST) begin
            map_in        = {rom_sel_ff, item_addr_ff[13:0]};
            region_in     = REGION_ROM;
            addr_valid_in = 1'b1;
         end else if (item_addr_ff >= XRAM_FIRST && item_addr_ff <= XRAM_LAST) begin
            addr_valid_in = 1'b1;
            if (ram_sel_ff <= RAM_BANK_MAX[RAM_SEL_W-1:0]) begin
               map_in    = {{(MAP_W-RAM_SEL_W-13){1'b0}}, ram_sel_ff, item_addr_ff[12:0]};
               region_in = REGION_RAM;
            end else begin
               map_in    = {{(MAP_W-RAM_CNT_W-13){1'b0}}, ram_count_ff, 10'd0,
                            rtc_slot[2:0]};
               region_in = REGION_RTC;
            end
         end
      end
   end

   // Capture item, step divider, load result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff  <= req_command;
         item_addr_ff <= req_bus_address;
         item_data_ff <= req_write_data;
      end
      if (cmd.div_start) begin
         rem_ff     <= '0;
         bit_idx_ff <= DIV_IDX_W'(DIV_BITS - 1);
      end else if (cmd.div_step) begin
         rem_ff     <= rem_in;
         bit_idx_ff <= bit_idx_ff - 1'b1;
      end
      if (cmd.commit) begin
         map_ff         <= map_in;
         region_ff      <= region_in;
         addr_valid_ff  <= addr_valid_in;
         ram_enabled_ff <= ram_en_in;
         pulse_ff       <= pulse_in;
      end
   end

   // Configuration and mapper state
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_count_ff <= ROM_CNT_RESET;
         ram_count_ff <= RAM_CNT_RESET;
         rom_sel_ff   <= ROM_SEL_RESET;
         ram_sel_ff   <= '0;
         ram_en_ff    <= 1'b0;
         latch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROM_BANK_COUNT: rom_count_ff <= csr_write_data;
               CSR_RAM_BANK_COUNT: ram_count_ff <= csr_write_data[RAM_CNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.commit) begin
            rom_sel_ff <= rom_sel_in;
            ram_sel_ff <= ram_sel_in;
            ram_en_ff  <= ram_en_in;
            latch_ff   <= latch_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mapped_address = map_ff;
   assign rsp_region         = region_ff;
   assign rsp_address_valid  = addr_valid_ff;
   assign rsp_ram_enabled    = ram_enabled_ff;
   assign rsp_rtc_tick_pulse = pulse_ff;

   a_ram_sel_range: assert property (@(posedge clock) disable iff (reset)
      ram_sel_ff <= RAM_SEL_MAX)
      else $error("RAM/RTC selection out of range");

   a_region_matches_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((region_ff == REGION_NONE) == !addr_valid_ff))
      else $error("region and address_valid disagree");

endmodule

### sv/cartridge_bank_mapper_core.sv
// Cartridge bank mapper core (MBC3-style bank controller).
// Request channel (req_*): one item per valid/ready handshake. req_command
// selects a register write (bank, RAM enable, latch) or an address translation.
// Response channel (rsp_*): exactly one item per request, in order, holding
// the mapped offset, its region, address_valid, the RAM enable flag after
// the item and the RTC tick pulse of a latch 0 -> 1 write.
// Configuration port (csr_*): index 0 is the ROM bank count, index 1 the RAM
// bank count; a write lands at the clock edge where csr_write_enable is high.
// Sequence: a request is taken in IDLE and evaluated in EXEC, and its response is
// registered once the response register is free; ROM and RAM bank writes that need
// a modulo first pass through DIV and FIN, since the shared restoring remainder unit
// resolves one bit of the 7-bit value per cycle. No new request is taken until the
// current item has committed.
// Reset (synchronous): ROM bank 1, RAM bank 0, RAM disabled, latch 0, ROM bank
// count 128, RAM bank count 4; no response pending.
// Receiver stall: the response register holds its item; the next request is
// still taken and evaluated, and waits to commit until the register frees.
module cartridge_bank_mapper_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [cbm_pkg::ADDR_W-1:0]     req_bus_address,
   input  logic [cbm_pkg::DATA_W-1:0]     req_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cbm_pkg::MAP_W-1:0]      rsp_mapped_address,
   output logic [cbm_pkg::REGION_W-1:0]   rsp_region,
   output logic                           rsp_address_valid,
   output logic                           rsp_ram_enabled,
   output logic                           rsp_rtc_tick_pulse,
   input  logic                           csr_write_enable,
   input  logic                           csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import cbm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_command        (req_command),
      .req_bus_address    (req_bus_address),
      .req_write_data     (req_write_data),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mapped_address (rsp_mapped_address),
      .rsp_region         (rsp_region),
      .rsp_address_valid  (rsp_address_valid),
      .rsp_ram_enabled    (rsp_ram_enabled),
      .rsp_rtc_tick_pulse (rsp_rtc_tick_pulse)
   );

endmodule

### test/cartridge_bank_mapper_core_tb.sv
module cartridge_bank_mapper_core_tb;
   import cbm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 80;

   typedef struct packed {
      logic [MAP_W-1:0]    mapped_address;
      logic [REGION_W-1:0] region;
      logic                address_valid;
      logic                ram_enabled;
      logic                rtc_tick_pulse;
   } bank_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_command;
   logic [ADDR_W-1:0]     req_bus_address;
   logic [DATA_W-1:0]     req_write_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [MAP_W-1:0]      rsp_mapped_address;
   logic [REGION_W-1:0]   rsp_region;
   logic                  rsp_address_valid;
   logic                  rsp_ram_enabled;
   logic                  rsp_rtc_tick_pulse;
   logic                  csr_write_enable;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // Predicted controller state and bank counts
   logic [ROM_CNT_W-1:0] rom_banks     = ROM_CNT_RESET;
   logic [RAM_CNT_W-1:0] ram_banks     = RAM_CNT_RESET;
   logic [ROM_SEL_W-1:0] cur_rom_bank  = ROM_SEL_RESET;
   logic [RAM_SEL_W-1:0] cur_ram_sel   = '0;
   logic                 ram_en_flag   = 1'b0;
   logic [DATA_W-1:0]    latch_byte    = '0;

   bank_result_type predicted_rsp_q[$];
   int error_count   = 0;
   int idle_cycles   = 0;
   int burst_left    = 0;
   bit gaps_off      = 1'b0;
   int hold_off_left = 0;
   int rx_cycle      = 0;

   cartridge_bank_mapper_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_bus_address    (req_bus_address),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mapped_address (rsp_mapped_address),
      .rsp_region         (rsp_region),
      .rsp_address_valid  (rsp_address_valid),
      .rsp_ram_enabled    (rsp_ram_enabled),
      .rsp_rtc_tick_pulse (rsp_rtc_tick_pulse),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Apply one bus item to the predicted state and return its response
   function automatic bank_result_type predict_bank_access(input logic cmd,
                                                           input logic [ADDR_W-1:0] a,
                                                           input logic [DATA_W-1:0] d);
      bank_result_type r;
      logic [31:0]     tmp;
      r = '0;
      r.region = REGION_NONE;
      if (cmd == CMD_WRITE) begin
         if (a <= RAM_EN_LAST) begin
            ram_en_flag = (d[3:0] == RAM_EN_KEY);
         end else if (a <= ROM_SEL_LAST) begin
            tmp = {25'd0, d[6:0]};
            if (tmp == 0)
               cur_rom_bank = 7'd1;
            else if (rom_banks == 0)
               cur_rom_bank = tmp[6:0];
            else begin
               tmp = tmp % rom_banks;
               cur_rom_bank = tmp[6:0];
            end
         end else if (a <= RAM_SEL_LAST) begin
            if (d == 0)
               cur_ram_sel = '0;
            if (d <= RAM_BANK_MAX && ram_banks != 0) begin
               tmp = 32'(d % ram_banks);
               cur_ram_sel = tmp[3:0];
            end else if (d >= RTC_SEL_FIRST && d <= RTC_SEL_LAST)
               cur_ram_sel = d[3:0];
         end else if (a <= LATCH_LAST) begin
            r.rtc_tick_pulse = (d == LATCH_ARM && latch_byte == 0);
            latch_byte = d;
         end
      end else if (a <= BANK0_LAST) begin
         r.mapped_address = MAP_W'(a);
         r.region = REGION_ROM;
         r.address_valid = 1'b1;
      end else if (a <= ROMX_LAST) begin
         r.mapped_address = {cur_rom_bank, a[13:0]};
         r.region = REGION_ROM;
         r.address_valid = 1'b1;
      end else if (a >= XRAM_FIRST && a <= XRAM_LAST) begin
         r.address_valid = 1'b1;
         if (cur_ram_sel <= RAM_BANK_MAX) begin
            r.mapped_address = MAP_W'({cur_ram_sel, a[12:0]});
            r.region = REGION_RAM;
         end else begin
            tmp = 32'h2000 * ram_banks + (cur_ram_sel - RTC_BASE_SEL);
            r.mapped_address = tmp[MAP_W-1:0];
            r.region = REGION_RTC;
         end
      end
      r.ram_enabled = ram_en_flag;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < 40)
         $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin : rsp_check
      bank_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_rsp_q.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_mapped_address, 0);
         end else begin
            want = predicted_rsp_q.pop_front();
            if (rsp_mapped_address !== want.mapped_address)
               report_mismatch("mapped_address", rsp_mapped_address, want.mapped_address);
            if (rsp_region !== want.region)
               report_mismatch("region", rsp_region, want.region);
            if (rsp_address_valid !== want.address_valid)
               report_mismatch("address_valid", rsp_address_valid, want.address_valid);
            if (rsp_ram_enabled !== want.ram_enabled)
               report_mismatch("ram_enabled", rsp_ram_enabled, want.ram_enabled);
            if (rsp_rtc_tick_pulse !== want.rtc_tick_pulse)
               report_mismatch("rtc_tick_pulse", rsp_rtc_tick_pulse, want.rtc_tick_pulse);
         end
      end
   end

   // Stall the response side: long hold-off first, else a rotating pattern
   always @(posedge clock) begin
      rx_cycle++;
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left--;
      end else begin
         case (rx_cycle[9:8])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ready <= (rx_cycle[1:0] == 2'd0);
            default: rsp_ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // End the run when no item moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offer one item, idling first when the current burst is used up
   task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
      if (!gaps_off && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end else if (burst_left > 0) begin
         burst_left--;
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_bus_address <= addr;
      req_write_data  <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted_rsp_q.push_back(predict_bank_access(cmd, addr, data));
   endtask

   // Drop valid and wait until every predicted response has arrived
   task automatic wait_drained;
      req_valid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] val);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_ROM_BANK_COUNT)
         rom_banks = val[ROM_CNT_W-1:0];
      else
         ram_banks = val[RAM_CNT_W-1:0];
   endtask

   task automatic set_bank_counts(input int rom_count, input int ram_count);
      write_csr(CSR_ROM_BANK_COUNT, CSR_DATA_W'(rom_count));
      write_csr(CSR_RAM_BANK_COUNT, CSR_DATA_W'(ram_count));
   endtask

   // Mix of bank-switch-then-access sequences and fully random items
   task automatic send_bank_traffic(input int count);
      int               sent;
      int               kind;
      logic             cmd;
      logic [ADDR_W-1:0] a;
      logic [DATA_W-1:0] d;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         d = DATA_W'($urandom);
         if (kind < 3) begin
            cmd = 1'($urandom_range(0, 1));
            a = ADDR_W'($urandom);
            send_item(cmd, a, d);
            sent++;
         end else if (kind < 5) begin
            // switch ROM bank, then read the switchable window
            send_item(CMD_WRITE, ADDR_W'($urandom_range(ROM_SEL_FIRST, ROM_SEL_LAST)), d);
            sent++;
            repeat ($urandom_range(1, 3)) begin
               send_item(CMD_TRANSLATE, ADDR_W'($urandom_range(RAM_SEL_FIRST, ROMX_LAST)),
                         DATA_W'($urandom));
               sent++;
            end
         end else if (kind < 8) begin
            // select a RAM bank or RTC register, then access external RAM
            if ($urandom_range(0, 3) != 0)
               d = DATA_W'($urandom_range(0, 15));
            send_item(CMD_WRITE, ADDR_W'($urandom_range(RAM_SEL_FIRST, RAM_SEL_LAST)), d);
            sent++;
            repeat ($urandom_range(1, 3)) begin
               send_item(CMD_TRANSLATE, ADDR_W'($urandom_range(XRAM_FIRST, XRAM_LAST)),
                         DATA_W'($urandom));
               sent++;
            end
         end else if (kind == 8) begin
            // latch writes, biased toward the arming values
            if ($urandom_range(0, 2) != 0)
               d = DATA_W'($urandom_range(0, 1));
            send_item(CMD_WRITE, ADDR_W'($urandom_range(LATCH_FIRST, LATCH_LAST)), d);
            sent++;
         end else begin
            // RAM enable, half of them with the enable key
            if ($urandom_range(0, 1) != 0)
               d[3:0] = RAM_EN_KEY;
            send_item(CMD_WRITE, ADDR_W'($urandom_range(0, RAM_EN_LAST)), d);
            sent++;
         end
      end
   endtask

   task automatic test_reset_translations;
      send_item(CMD_TRANSLATE, BANK0_LAST, 8'h00);
      send_item(CMD_TRANSLATE, RAM_SEL_FIRST, 8'hFF);
      send_item(CMD_TRANSLATE, 16'h9FFF, 8'h00);
      send_item(CMD_TRANSLATE, XRAM_FIRST, 8'h00);
      send_item(CMD_TRANSLATE, XRAM_LAST, 8'h00);
      send_item(CMD_TRANSLATE, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_register_writes;
      send_item(CMD_WRITE, 16'h0000, 8'h0A);
      send_item(CMD_WRITE, RAM_EN_LAST, 8'h0B);
      // bank 0 written becomes bank 1; top bit of the byte is dropped
      send_item(CMD_WRITE, ROM_SEL_FIRST, 8'h00);
      send_item(CMD_WRITE, ROM_SEL_LAST, 8'hFF);
      send_item(CMD_TRANSLATE, ROMX_LAST, 8'h00);
      send_item(CMD_WRITE, RAM_SEL_LAST, RTC_SEL_FIRST);
      send_item(CMD_TRANSLATE, XRAM_FIRST, 8'h00);
      send_item(CMD_WRITE, RAM_SEL_FIRST, 8'h0D);
      send_item(CMD_WRITE, RAM_SEL_FIRST, 8'h00);
      // latch pulses only on a 0 to 1 transition
      send_item(CMD_WRITE, LATCH_FIRST, LATCH_ARM);
      send_item(CMD_WRITE, LATCH_LAST, LATCH_ARM);
      send_item(CMD_WRITE, LATCH_FIRST, 8'h00);
      send_item(CMD_WRITE, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_config_extremes;
      // zero ROM banks: bank number is taken as written
      set_bank_counts(0, 4);
      send_item(CMD_WRITE, ROM_SEL_FIRST, 8'h7F);
      send_item(CMD_TRANSLATE, RAM_SEL_FIRST, 8'h00);
      // one ROM bank yields bank 0, and no RAM banks ignores RAM selects
      set_bank_counts(1, 0);
      send_item(CMD_WRITE, ROM_SEL_FIRST, 8'h05);
      send_item(CMD_WRITE, RAM_SEL_FIRST, 8'h03);
      send_item(CMD_TRANSLATE, 16'h5555, 8'h00);
      // largest counts, RTC slot past sixteen RAM banks
      set_bank_counts(512, 16);
      send_item(CMD_WRITE, RAM_SEL_FIRST, RTC_SEL_LAST);
      send_item(CMD_TRANSLATE, XRAM_LAST, 8'h00);
      send_item(CMD_WRITE, ROM_SEL_FIRST, 8'h7F);
      send_item(CMD_TRANSLATE, ROMX_LAST, 8'h00);
   endtask

   task automatic test_random_traffic;
      int rom_choices[12] = '{1, 2, 3, 5, 7, 64, 100, 127, 128, 129, 200, 512};
      int ram_choices[9]  = '{0, 1, 2, 3, 4, 5, 8, 15, 16};
      int rom_count;
      int ram_count;
      for (int phase = 0; phase < 8; phase++) begin
         rom_count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 512)
                                                 : rom_choices[$urandom_range(0, 11)];
         ram_count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16)
                                                 : ram_choices[$urandom_range(0, 8)];
         set_bank_counts(rom_count, ram_count);
         send_bank_traffic(125);
      end
   endtask

   // Hold the response side off while items keep coming, so the input stalls
   task automatic test_input_backpressure;
      gaps_off = 1'b1;
      hold_off_left = HOLD_OFF_CYCLES;
      send_bank_traffic(30);
      gaps_off = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = CMD_WRITE;
      req_bus_address  = '0;
      req_write_data   = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ROM_BANK_COUNT;
      csr_write_data   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_translations();
      test_register_writes();
      test_config_extremes();
      test_random_traffic();
      test_input_backpressure();

      // drain, then leave room for any stray response
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && predicted_rsp_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### cartridge_bank_mapper_core.f
sv/cbm_pkg.sv
sv/cbm_ctrl.sv
sv/cbm_datapath.sv
sv/cartridge_bank_mapper_core.sv
test/cartridge_bank_mapper_core_tb.sv
